/* sv/sender_report_clock_drift_tracker_defines.svh */
// Assertion macros shared by the clock drift tracker.
`ifndef SENDER_REPORT_CLOCK_DRIFT_TRACKER_DEFINES_SVH
`define SENDER_REPORT_CLOCK_DRIFT_TRACKER_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define SRCD_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define SRCD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

/* sv/srcd_pkg.sv */
// Package with the shared types and constants of the clock drift tracker.
package srcd_pkg;
    localparam logic [2:0] ST_ACCEPT  = 3'd0;
    localparam logic [2:0] ST_NO_REP  = 3'd1;
    localparam logic [2:0] ST_BEHIND  = 3'd2;
    localparam logic [2:0] ST_REP_OK  = 3'd3;
    localparam logic [2:0] ST_REP_BAD = 3'd4;
    localparam logic [15:0] INTERVAL_RESET = 16'd1000;
    localparam logic [36:0] PPM_Q16_SCALE = 37'd65536000000;
    localparam logic [47:0] SAT_POS = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] SAT_NEG = 48'h8000_0000_0000;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;    // latch the input transaction and evaluate it
        logic div_start;  // load the divider for the current operand
        logic div_sel;    // 0 last period, 1 since start
        logic div_step;   // one restoring division step
        logic div_store;  // store the saturated quotient
        logic commit;     // update state and form the result
    } srcd_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_frame;
        logic frame_ok;
        logic need;
    } srcd_stat_t;

    function automatic logic rtp_before(input logic [31:0] a, input logic [31:0] b);
        if (a[31] == b[31])
            rtp_before = a < b;
        else
            rtp_before = a[30:0] > b[30:0];
    endfunction
endpackage

/* sv/srcd_ctrl.sv */
// Controller state machine of the clock drift tracker.
module srcd_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_fire,
    input  logic                 out_fire,
    input  srcd_pkg::srcd_stat_t stat,
    output srcd_pkg::srcd_cmd_t  cmd,
    output logic                 busy,
    output logic                 out_valid
);
    import srcd_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_EVAL  = 6'b000010,
        S_LOAD  = 6'b000100,
        S_DIV   = 6'b001000,
        S_STORE = 6'b010000,
        S_OUT   = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic [6:0] cnt_reg, cnt_next;
    logic sel_reg, sel_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        sel_next = sel_reg;
        cmd = '0;
        cmd.div_sel = sel_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    cmd.capture = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (stat.is_frame && stat.frame_ok && stat.need)
                begin
                    sel_next = 1'b0;
                    state_next = S_LOAD;
                end
                else
                begin
                    cmd.commit = 1'b1;
                    state_next = S_OUT;
                end
            end
            S_LOAD:
            begin
                cmd.div_start = 1'b1;
                cnt_next = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'd127)
                    state_next = S_STORE;
            end
            S_STORE:
            begin
                cmd.div_store = 1'b1;
                if (sel_reg)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_OUT;
                end
                else
                begin
                    sel_next = 1'b1;
                    state_next = S_LOAD;
                end
            end
            S_OUT:
            begin
                if (out_fire)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_OUT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg <= '0;
            sel_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            sel_reg <= sel_next;
        end
    end
endmodule

/* sv/srcd_dp.sv */
// Datapath of the clock drift tracker: kept report, drift state and divider.
module srcd_dp
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  srcd_pkg::srcd_cmd_t  cmd,
    output srcd_pkg::srcd_stat_t stat,
    input  logic [15:0]          stats_period,
    input  logic                 op,
    input  logic                 report_ok,
    input  logic [7:0]           info_version,
    input  logic [31:0]          rtp_time,
    input  logic [63:0]          sender_time,
    input  logic [63:0]          receive_time,
    output logic [2:0]           status,
    output logic                 new_stream_info,
    output logic                 stats_updated,
    output logic signed [63:0]   clock_offset,
    output logic signed [63:0]   drift_last,
    output logic signed [47:0]   ppm_last,
    output logic signed [63:0]   drift_total,
    output logic signed [47:0]   ppm_total,
    output logic signed [63:0]   delay_min,
    output logic signed [63:0]   delay_max
);
    import srcd_pkg::*;

    // Captured transaction.
    logic op_reg, ok_reg;
    logic [7:0] ver_reg;
    logic [31:0] rtp_reg;
    logic [63:0] stime_reg, rx_reg;
    // Kept report and tracking state.
    logic rep_valid_reg, seen_reg;
    logic [31:0] rep_rtp_reg;
    logic [63:0] rep_stime_reg, rep_arr_reg;
    logic [7:0] rep_ver_reg;
    logic [63:0] last_rx_reg, period_rx_reg, period_diff_reg;
    logic [63:0] start_rx_reg, start_diff_reg, min_reg, max_reg;
    logic need_reg;
    // Divider.
    logic [127:0] num_reg;
    logic [63:0] rem_reg, dmag_reg;
    logic [127:0] quo_reg;
    logic neg_reg, dzero_reg;
    logic [47:0] ppm_l_reg;

    logic [63:0] diff, delay, dl, dt, num_sel, den_sel, nmag, dmag;
    logic first, no_rep, acc, upd;
    logic signed [16:0] ms_m1;
    logic signed [63:0] thr;
    logic [64:0] rem_sh;
    logic [63:0] qmag;
    logic [47:0] ppm_val;
    logic [77:0] nx, nscaled;

    assign diff = rx_reg - rep_stime_reg;
    assign delay = rx_reg - rep_arr_reg;
    assign first = !seen_reg;
    assign dl = diff - (first ? diff : period_diff_reg);
    assign dt = diff - (first ? diff : start_diff_reg);
    assign ms_m1 = $signed({1'b0, stats_period}) - 17'sd1;
    assign thr = 64'(ms_m1 * 38'sd1000000);

    assign no_rep = !rep_valid_reg || rtp_before(rep_rtp_reg, rtp_reg);
    assign stat.is_frame = op_reg;
    assign stat.frame_ok = !no_rep && !rtp_before(rtp_reg, rep_rtp_reg);
    assign stat.need = need_reg;
    assign acc = op_reg && stat.frame_ok;
    assign upd = acc && need_reg;

    assign num_sel = cmd.div_sel ? dt : dl;
    assign den_sel = cmd.div_sel ? (rx_reg - (first ? rx_reg : start_rx_reg))
                                 : (rx_reg - (first ? rx_reg : period_rx_reg));
    assign nmag = num_sel[63] ? (64'd0 - num_sel) : num_sel;
    assign dmag = den_sel[63] ? (64'd0 - den_sel) : den_sel;
    // The Q.16 ppm scale is 15625 * 2^22; 15625 = 2^14 - 2^10 + 2^8 + 2^3 + 1.
    assign nx = {14'd0, nmag};
    assign nscaled = (nx << 14) - (nx << 10) + (nx << 8) + (nx << 3) + nx;

    assign rem_sh = {rem_reg, num_reg[127]};
    assign qmag = (quo_reg[127:64] != 0 || quo_reg[63:0] > {16'd0, SAT_NEG})
                  ? {16'd0, SAT_NEG} + 64'd1 : quo_reg[63:0];

    always_comb
    begin
        if (dzero_reg)
            ppm_val = '0;
        else if (neg_reg)
            ppm_val = (qmag > {16'd0, SAT_NEG}) ? SAT_NEG : (48'd0 - qmag[47:0]);
        else
            ppm_val = (qmag > {16'd0, SAT_POS}) ? SAT_POS : qmag[47:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg <= op;
            ok_reg <= report_ok;
            ver_reg <= info_version;
            rtp_reg <= rtp_time;
            stime_reg <= sender_time;
            rx_reg <= receive_time;
            need_reg <= $signed(last_rx_reg - period_rx_reg) >= thr;
        end
        if (cmd.div_start)
        begin
            num_reg <= {28'd0, nscaled, 22'd0};
            rem_reg <= '0;
            quo_reg <= '0;
            dmag_reg <= dmag;
            neg_reg <= num_sel[63] != den_sel[63];
            dzero_reg <= (dmag == 64'd0);
        end
        if (cmd.div_step)
        begin
            num_reg <= {num_reg[126:0], 1'b0};
            if (rem_sh >= {1'b0, dmag_reg})
            begin
                rem_reg <= rem_sh[63:0] - dmag_reg;
                quo_reg <= {quo_reg[126:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh[63:0];
                quo_reg <= {quo_reg[126:0], 1'b0};
            end
        end
        // The since-start quotient is taken straight from the divider at commit.
        if (cmd.div_store && !cmd.div_sel)
            ppm_l_reg <= ppm_val;
        if (cmd.commit)
        begin
            if (!op_reg)
                status <= ok_reg ? ST_REP_OK : ST_REP_BAD;
            else if (no_rep)
                status <= ST_NO_REP;
            else if (!stat.frame_ok)
                status <= ST_BEHIND;
            else
                status <= ST_ACCEPT;
            new_stream_info <= !op_reg && ok_reg && (!rep_valid_reg || ver_reg != rep_ver_reg);
            stats_updated <= upd;
            clock_offset <= acc ? diff : '0;
            drift_last <= upd ? dl : '0;
            ppm_last <= upd ? ppm_l_reg : '0;
            drift_total <= upd ? dt : '0;
            ppm_total <= upd ? ppm_val : '0;
            delay_min <= !acc ? '0
                       : (first || $signed(delay) < $signed(min_reg)) ? delay : min_reg;
            delay_max <= !acc ? '0
                       : (first || $signed(delay) > $signed(max_reg)) ? delay : max_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rep_valid_reg <= 1'b0;
            seen_reg <= 1'b0;
            rep_rtp_reg <= '0;
            rep_stime_reg <= '0;
            rep_arr_reg <= '0;
            rep_ver_reg <= '0;
            last_rx_reg <= '0;
            period_rx_reg <= '0;
            period_diff_reg <= '0;
            start_rx_reg <= '0;
            start_diff_reg <= '0;
            min_reg <= '0;
            max_reg <= '0;
        end
        else if (cmd.commit)
        begin
            if (!op_reg)
            begin
                rep_arr_reg <= rx_reg;
                rep_valid_reg <= ok_reg;
                if (ok_reg)
                begin
                    rep_rtp_reg <= rtp_reg;
                    rep_stime_reg <= stime_reg;
                    rep_ver_reg <= ver_reg;
                end
            end
            else if (stat.frame_ok)
            begin
                seen_reg <= 1'b1;
                last_rx_reg <= rx_reg;
                if (first)
                begin
                    start_rx_reg <= rx_reg;
                    start_diff_reg <= diff;
                end
                if (first || need_reg)
                begin
                    period_rx_reg <= rx_reg;
                    period_diff_reg <= diff;
                end
                if (first || $signed(delay) < $signed(min_reg))
                    min_reg <= delay;
                if (first || $signed(delay) > $signed(max_reg))
                    max_reg <= delay;
            end
        end
    end
endmodule

/* sv/sender_report_clock_drift_tracker.sv */
// Top level of the sender-report clock drift tracker.
// The block takes one transaction at a time on the input channel (valid and
// ready): either a sender report (op 0) or a data frame (op 1). Each input
// transaction gives exactly one result transaction on the output channel.
// A report, a rejected frame or a frame without a statistics update is
// evaluated in the EVAL state; the result is offered the cycle after that,
// and a new input is taken only once that result has been delivered. A
// frame that closes a statistics period runs two 128-step restoring
// divisions for the ppm figures, last period first and then since start,
// one step per cycle in a single shared divider; its result is offered
// once both quotients are stored, and the next input waits for its delivery.
// The divider sets the throughput; ready returns high the cycle after the
// result transaction completes.
// When the receiver stalls, the result is held in its output registers and
// no new input is taken until it is delivered.
// Reset (rst_n low, asynchronous) clears the kept report, the drift state
// and the controller; the statistics interval register returns to 1000 ms.
// The register is written over the APB port at address 0 and should be
// written only while the block is idle.
module sender_report_clock_drift_tracker
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [1:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               op,
    input  logic               report_ok,
    input  logic [7:0]         info_version,
    input  logic [31:0]        rtp_time,
    input  logic [63:0]        sender_time,
    input  logic [63:0]        receive_time,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [2:0]         status,
    output logic               new_stream_info,
    output logic               stats_updated,
    output logic signed [63:0] clock_offset,
    output logic signed [63:0] drift_last,
    output logic signed [47:0] ppm_last,
    output logic signed [63:0] drift_total,
    output logic signed [47:0] ppm_total,
    output logic signed [63:0] delay_min,
    output logic signed [63:0] delay_max
);
    import srcd_pkg::*;
`include "sender_report_clock_drift_tracker_defines.svh"

    logic [15:0] interval_reg;
    srcd_cmd_t cmd;
    srcd_stat_t stat;
    logic busy, in_fire, out_fire;

    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? {16'd0, interval_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            interval_reg <= INTERVAL_RESET;
        else if (psel && penable && pwrite && paddr == 2'd0)
            interval_reg <= pwdata[15:0];
    end

    assign in_ready = !busy;
    assign in_fire = in_valid && in_ready;
    assign out_fire = out_valid && out_ready;

    srcd_ctrl u_ctrl
    (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .out_fire(out_fire),
        .stat(stat), .cmd(cmd), .busy(busy), .out_valid(out_valid)
    );

    srcd_dp u_dp
    (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat), .stats_period(interval_reg),
        .op(op), .report_ok(report_ok), .info_version(info_version),
        .rtp_time(rtp_time), .sender_time(sender_time), .receive_time(receive_time),
        .status(status), .new_stream_info(new_stream_info),
        .stats_updated(stats_updated), .clock_offset(clock_offset),
        .drift_last(drift_last), .ppm_last(ppm_last), .drift_total(drift_total),
        .ppm_total(ppm_total), .delay_min(delay_min), .delay_max(delay_max)
    );

    // An accepted input leaves the block busy in the next cycle.
    `SRCD_ASSERT_NEXT(a_busy_after_accept, in_fire, busy)
    // A result is only shown while a transaction is in flight.
    `SRCD_ASSERT_IMP(a_valid_busy, out_valid, busy)
    // Only accepted frames can report a statistics update.
    `SRCD_ASSERT_IMP(a_upd_accept, out_valid && stats_updated, status == ST_ACCEPT)
endmodule
